/* rtl/vfpt_pkg.sv */
// ----------------------------------------------------------------------------
// vfpt_pkg
// shared types, constants and saturation helper for the frustum point test
// ----------------------------------------------------------------------------
package vfpt_pkg;

   localparam int NumRegs       = 8;
   localparam int CsrIndexWidth = 4;
   localparam int MarginWidth   = 17;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] RegXFirst     = 4'd0;
   localparam logic [CsrIndexWidth-1:0] RegXSecond    = 4'd1;
   localparam logic [CsrIndexWidth-1:0] RegYFirst     = 4'd2;
   localparam logic [CsrIndexWidth-1:0] RegYSecond    = 4'd3;
   localparam logic [CsrIndexWidth-1:0] RegDepthFirst = 4'd4;
   localparam logic [CsrIndexWidth-1:0] RegDepthSecond= 4'd5;
   localparam logic [CsrIndexWidth-1:0] RegNearFar    = 4'd6;
   localparam logic [CsrIndexWidth-1:0] RegScales     = 4'd7;

   // margin modes
   localparam logic [1:0] ModeZero = 2'd0;
   localparam logic [1:0] ModeOne  = 2'd1;
   localparam logic [1:0] ModeDiv  = 2'd2;

   typedef logic [NumRegs-1:0][63:0] regs_type;

   typedef struct packed {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] depth;
   } view_type;

   typedef struct packed {
      logic                   outside;
      logic [MarginWidth-1:0] margin_x;
      logic [MarginWidth-1:0] margin_y;
   } rsp_type;

   function automatic logic signed [31:0] sat_word(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = 66'sh7FFFFFFF;
      lo = -66'sh80000000;
      if (v > hi) begin
         sat_word = 32'sh7FFFFFFF;
      end else if (v < lo) begin
         sat_word = 32'sh80000000;
      end else begin
         sat_word = v[31:0];
      end
   endfunction

endpackage

/* rtl/vfpt_fifo.sv */
// ----------------------------------------------------------------------------
// vfpt_fifo
// small register queue, caller guarantees no push when full
// ----------------------------------------------------------------------------
module vfpt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);
   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             do_pop;

   assign empty    = (cnt_ff == '0);
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= data_in;
      end
   end
endmodule

/* rtl/vfpt_front.sv */
// ----------------------------------------------------------------------------
// vfpt_front
// view transform: products in one stage, saturated row sums in the next
// ----------------------------------------------------------------------------
module vfpt_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [31:0]   point_x,
   input  logic signed [31:0]   point_y,
   input  logic signed [31:0]   point_z,
   input  vfpt_pkg::regs_type   regs,
   output logic                 out_valid,
   output vfpt_pkg::view_type   out_view
);
   logic signed [63:0] prod_ff [3][3];
   logic signed [63:0] prod_in [3][3];
   logic               vld_a_ff, vld_b_ff;
   logic signed [31:0] term [3][3];
   logic signed [34:0] sum [3];
   vfpt_pkg::view_type view_ff, view_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[r][0] = $signed(regs[2*r][63:32])   * point_x;
         prod_in[r][1] = $signed(regs[2*r][31:0])    * point_y;
         prod_in[r][2] = $signed(regs[2*r+1][63:32]) * point_z;
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            term[r][c] = vfpt_pkg::sat_word(66'(prod_ff[r][c] >>> FRAC_BITS));
         end
         sum[r] = 35'(term[r][0]) + 35'(term[r][1]) + 35'(term[r][2])
                + 35'($signed(regs[2*r+1][31:0]));
      end
      view_in.vx    = vfpt_pkg::sat_word(66'(sum[0]));
      view_in.vy    = vfpt_pkg::sat_word(66'(sum[1]));
      view_in.depth = vfpt_pkg::sat_word(66'(-sum[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_a_ff <= in_valid;
         vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      view_ff <= view_in;
   end

   assign out_valid = vld_b_ff;
   assign out_view  = view_ff;
endmodule

/* rtl/vfpt_back.sv */
// ----------------------------------------------------------------------------
// vfpt_back
// scaling, volume test and bit-per-stage margin division
// ----------------------------------------------------------------------------
module vfpt_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  vfpt_pkg::view_type in_view,
   input  vfpt_pkg::regs_type regs,
   output logic               out_valid,
   output vfpt_pkg::rsp_type  out_rsp
);
   // stage 1: scale products and depth range check
   logic               v1_ff;
   logic signed [64:0] sxp_ff, syp_ff;
   logic signed [31:0] d1_ff;
   logic               range_ff;
   logic signed [32:0] ax, ay;

   assign ax = in_view.vx[31] ? -33'(in_view.vx) : 33'(in_view.vx);
   assign ay = in_view.vy[31] ? -33'(in_view.vy) : 33'(in_view.vy);

   always_ff @(posedge clock) begin
      sxp_ff   <= ax * $signed(regs[vfpt_pkg::RegScales][63:32]);
      syp_ff   <= ay * $signed(regs[vfpt_pkg::RegScales][31:0]);
      d1_ff    <= in_view.depth;
      range_ff <= (in_view.depth < $signed(regs[vfpt_pkg::RegNearFar][63:32]))
               || ($signed(regs[vfpt_pkg::RegNearFar][31:0]) < in_view.depth);
   end

   // stage 2: visibility and division set-up
   logic signed [31:0] sx, sy;
   logic               outside;
   logic [1:0]         mode [2];
   logic [31:0]        num  [2];
   logic [31:0]        den;
   logic signed [31:0] sv   [2];

   always_comb begin
      sx      = vfpt_pkg::sat_word(66'(sxp_ff >>> FRAC_BITS));
      sy      = vfpt_pkg::sat_word(66'(syp_ff >>> FRAC_BITS));
      outside = range_ff || (d1_ff < sx) || (d1_ff < sy);
      sv[0]   = sx;
      sv[1]   = sy;
      den     = d1_ff[31] ? 32'(-33'(d1_ff)) : d1_ff;
      for (int l = 0; l < 2; l++) begin
         num[l] = sv[l][31] ? 32'(-33'(sv[l])) : sv[l];
         if (outside || d1_ff == '0) begin
            mode[l] = vfpt_pkg::ModeZero;
         end else if (sv[l] == '0 || (sv[l][31] != d1_ff[31])) begin
            mode[l] = vfpt_pkg::ModeOne;
         end else if (num[l] >= den) begin
            mode[l] = vfpt_pkg::ModeZero;
         end else begin
            mode[l] = vfpt_pkg::ModeDiv;
         end
      end
   end

   // division pipeline, one quotient bit per stage
   logic                 vld_ff  [FRAC_BITS+1];
   logic                 out_ff  [FRAC_BITS+1];
   logic [31:0]          den_ff  [FRAC_BITS+1];
   logic [31:0]          rem_ff  [FRAC_BITS+1][2];
   logic [FRAC_BITS-1:0] q_ff    [FRAC_BITS+1][2];
   logic [1:0]           mode_ff [FRAC_BITS+1][2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else begin
         v1_ff     <= in_valid;
         vld_ff[0] <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_ff[0] <= outside;
      den_ff[0] <= den;
      for (int l = 0; l < 2; l++) begin
         rem_ff[0][l]  <= num[l];
         q_ff[0][l]    <= '0;
         mode_ff[0][l] <= mode[l];
      end
   end

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
      logic [32:0] shifted [2];
      logic        fits    [2];

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            shifted[l] = {rem_ff[k][l], 1'b0};
            fits[l]    = shifted[l] >= {1'b0, den_ff[k]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         out_ff[k+1] <= out_ff[k];
         den_ff[k+1] <= den_ff[k];
         for (int l = 0; l < 2; l++) begin
            rem_ff[k+1][l]  <= fits[l] ? 32'(shifted[l] - {1'b0, den_ff[k]})
                                       : shifted[l][31:0];
            q_ff[k+1][l]    <= {q_ff[k][l][FRAC_BITS-2:0], fits[l]};
            mode_ff[k+1][l] <= mode_ff[k][l];
         end
      end
   end

   // margin = one - quotient, or a fixed value
   logic [FRAC_BITS:0] marg [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         unique case (mode_ff[FRAC_BITS][l])
            vfpt_pkg::ModeOne: marg[l] = (FRAC_BITS+1)'(1) << FRAC_BITS;
            vfpt_pkg::ModeDiv: marg[l] = ((FRAC_BITS+1)'(1) << FRAC_BITS)
                                       - (FRAC_BITS+1)'(q_ff[FRAC_BITS][l]);
            default:           marg[l] = '0;
         endcase
      end
   end

   assign out_valid        = vld_ff[FRAC_BITS];
   assign out_rsp.outside  = out_ff[FRAC_BITS];
   assign out_rsp.margin_x = vfpt_pkg::MarginWidth'(marg[0]);
   assign out_rsp.margin_y = vfpt_pkg::MarginWidth'(marg[1]);
endmodule

/* rtl/view_frustum_point_test_unit.sv */
// ----------------------------------------------------------------------------
// view_frustum_point_test_unit
// frustum culling test of one point per word, fixed point with saturation
// ----------------------------------------------------------------------------
// One point word is taken every cycle while full is low, and one result word
// leaves every cycle while it is popped. A front pipeline of products and row
// sums transforms the point by the 3x4 view matrix; a four-word queue decouples
// it from the back pipeline, which scales, tests against the volume and derives
// both edge margins with a restoring divider of one quotient bit per stage.
// Each side admits words only against free places in the queue that follows it,
// so neither pipeline ever stalls. Registers are written through the csr port at
// any time, csr_ready is always high, and writes to indexes above seven are
// dropped; they must only change while the unit holds no words.
module view_frustum_point_test_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // point words
   input  logic                                 push,
   output logic                                 full,
   input  logic signed [31:0]                   req_point_x,
   input  logic signed [31:0]                   req_point_y,
   input  logic signed [31:0]                   req_point_z,
   // result words
   output logic                                 empty,
   input  logic                                 pop,
   output logic                                 rsp_outside,
   output logic [vfpt_pkg::MarginWidth-1:0]     rsp_margin_x,
   output logic [vfpt_pkg::MarginWidth-1:0]     rsp_margin_y,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [vfpt_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [63:0]                          csr_data
);
   localparam int MidDepth = 4;
   localparam int OutDepth = FRAC_BITS + 4;
   localparam int MidCntW  = $clog2(MidDepth + 1);
   localparam int OutCntW  = $clog2(OutDepth + 1);

   // configuration registers
   vfpt_pkg::regs_type regs_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else if (csr_valid && csr_index < vfpt_pkg::CsrIndexWidth'(vfpt_pkg::NumRegs)) begin
         regs_ff[csr_index[2:0]] <= csr_data;
      end
   end

   // front: transform
   logic               acc_in;
   logic               fr_valid;
   vfpt_pkg::view_type fr_view;

   assign acc_in = push && !full;

   vfpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (acc_in),
      .point_x  (req_point_x),
      .point_y  (req_point_y),
      .point_z  (req_point_z),
      .regs     (regs_ff),
      .out_valid(fr_valid),
      .out_view (fr_view)
   );

   // decoupling queue between the halves
   logic               mid_empty, mid_pop;
   vfpt_pkg::view_type mid_view;
   logic [MidCntW-1:0] mid_cnt_ff;
   logic [OutCntW-1:0] out_cnt_ff;

   vfpt_fifo #(.WIDTH($bits(vfpt_pkg::view_type)), .DEPTH(MidDepth)) u_mid (
      .clock   (clock),
      .reset   (reset),
      .push    (fr_valid),
      .data_in (fr_view),
      .pop     (mid_pop),
      .data_out(mid_view),
      .empty   (mid_empty)
   );

   // words in front pipe plus mid queue, and in back pipe plus result queue
   assign full    = (mid_cnt_ff == MidCntW'(MidDepth));
   assign mid_pop = !mid_empty && (out_cnt_ff != OutCntW'(OutDepth));

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_cnt_ff <= '0;
         out_cnt_ff <= '0;
      end else begin
         mid_cnt_ff <= mid_cnt_ff + MidCntW'(acc_in) - MidCntW'(mid_pop);
         out_cnt_ff <= out_cnt_ff + OutCntW'(mid_pop) - OutCntW'(pop && !empty);
      end
   end

   // back: test and margins
   logic              bk_valid;
   vfpt_pkg::rsp_type bk_rsp, out_rsp;

   vfpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mid_pop),
      .in_view  (mid_view),
      .regs     (regs_ff),
      .out_valid(bk_valid),
      .out_rsp  (bk_rsp)
   );

   vfpt_fifo #(.WIDTH($bits(vfpt_pkg::rsp_type)), .DEPTH(OutDepth)) u_out (
      .clock   (clock),
      .reset   (reset),
      .push    (bk_valid),
      .data_in (bk_rsp),
      .pop     (pop),
      .data_out(out_rsp),
      .empty   (empty)
   );

   assign rsp_outside  = out_rsp.outside;
   assign rsp_margin_x = out_rsp.margin_x;
   assign rsp_margin_y = out_rsp.margin_y;

   // checks
   a_mid_credit: assert property (@(posedge clock) disable iff (reset)
      mid_cnt_ff <= MidCntW'(MidDepth)) else $error("mid credit overrun");

   a_out_credit: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= OutCntW'(OutDepth)) else $error("result credit overrun");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_outside) |-> (rsp_margin_x == '0 && rsp_margin_y == '0))
      else $error("outside word with nonzero margin");

   a_full_no_mid: assert property (@(posedge clock) disable iff (reset)
      (mid_cnt_ff == '0) |-> mid_empty) else $error("mid queue word without credit");
endmodule

/* test/view_frustum_point_test_unit_test.sv */
// ----------------------------------------------------------------------------
// view_frustum_point_test_unit_test
// self-checking bench for the frustum point test unit
// ----------------------------------------------------------------------------
// Point words are pushed with random gaps and result words popped with random
// stalls. A fixed-point predictor computes the outside flag and both margins
// for every accepted point, and a scoreboard compares each popped result word
// with the oldest prediction. The register set is rewritten between phases,
// only while the unit holds no words.
// ----------------------------------------------------------------------------
module view_frustum_point_test_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FracBits = 16;
   localparam int CycleLimit = 400000;

   // scoreboard of predicted result words
   class margin_scoreboard;
      vfpt_pkg::rsp_type pending[$];
      int                mismatches;

      function void note_point(vfpt_pkg::rsp_type r);
         pending.push_back(r);
      endfunction

      function void check_result(vfpt_pkg::rsp_type got);
         vfpt_pkg::rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", got);
            return;
         end
         want = pending.pop_front();
         if (want.outside !== got.outside || want.margin_x !== got.margin_x ||
             want.margin_y !== got.margin_y) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                        want.outside, want.margin_x, want.margin_y,
                        got.outside, got.margin_x, got.margin_y);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic full;
   logic signed [31:0] req_point_x = 0, req_point_y = 0, req_point_z = 0;
   logic empty;
   logic pop = 0;
   logic rsp_outside;
   logic [vfpt_pkg::MarginWidth-1:0] rsp_margin_x, rsp_margin_y;
   logic csr_valid = 0;
   logic csr_ready;
   logic [vfpt_pkg::CsrIndexWidth-1:0] csr_index = 0;
   logic [63:0] csr_data = 0;

   view_frustum_point_test_unit #(.FRAC_BITS(FracBits)) u_dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   margin_scoreboard board = new();
   logic [63:0] matrix_regs [vfpt_pkg::NumRegs];
   int  cycle_count = 0;
   bit  popping_on = 0;

   // predictor arithmetic
   function automatic longint clamp_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint hi_word(int i);
      return longint'($signed(matrix_regs[i][63:32]));
   endfunction

   function automatic longint lo_word(int i);
      return longint'($signed(matrix_regs[i][31:0]));
   endfunction

   // exact product, floor shift, saturate
   function automatic longint fixed_mul(longint a, longint b);
      return clamp_word((a * b) >>> FracBits);
   endfunction

   function automatic longint row_total(int first, int second, longint px, longint py,
                                        longint pz);
      return fixed_mul(hi_word(first), px) + fixed_mul(lo_word(first), py) +
             fixed_mul(hi_word(second), pz) + lo_word(second);
   endfunction

   function automatic logic [vfpt_pkg::MarginWidth-1:0] edge_margin(longint scaled,
                                                                   longint depth);
      longint one, q, m;
      one = longint'(1) << FracBits;
      if (depth == 0) return '0;
      q = (scaled * one) / depth;
      m = one - q;
      if (m < 0) m = 0;
      if (m > one) m = one;
      return m[vfpt_pkg::MarginWidth-1:0];
   endfunction

   function automatic vfpt_pkg::rsp_type predict_cull(logic [31:0] x, logic [31:0] y,
                                                      logic [31:0] z);
      longint px, py, pz, depth, vx, vy, sx, sy;
      vfpt_pkg::rsp_type r;
      px = longint'($signed(x));
      py = longint'($signed(y));
      pz = longint'($signed(z));
      depth = clamp_word(-row_total(int'(vfpt_pkg::RegDepthFirst),
                                    int'(vfpt_pkg::RegDepthSecond), px, py, pz));
      vx = clamp_word(row_total(int'(vfpt_pkg::RegXFirst), int'(vfpt_pkg::RegXSecond),
                                px, py, pz));
      vy = clamp_word(row_total(int'(vfpt_pkg::RegYFirst), int'(vfpt_pkg::RegYSecond),
                                px, py, pz));
      if (vx < 0) vx = -vx;
      if (vy < 0) vy = -vy;
      sx = fixed_mul(vx, hi_word(int'(vfpt_pkg::RegScales)));
      sy = fixed_mul(vy, lo_word(int'(vfpt_pkg::RegScales)));
      r = '0;
      if (depth < hi_word(int'(vfpt_pkg::RegNearFar)) ||
          lo_word(int'(vfpt_pkg::RegNearFar)) < depth ||
          depth < sx || depth < sy) begin
         r.outside = 1'b1;
      end else begin
         r.margin_x = edge_margin(sx, depth);
         r.margin_y = edge_margin(sy, depth);
      end
      return r;
   endfunction

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL view_frustum_point_test_unit");
         $finish;
      end
   end

   // result side: random stalls, check every accepted word
   always @(posedge clock) begin
      if (!reset && pop && !empty)
         board.check_result('{rsp_outside, rsp_margin_x, rsp_margin_y});
   end

   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (!popping_on) begin
            pop <= 0;
         end else if (pop && !empty) begin
            gap = $urandom_range(0, 3);
            if (gap == 0) begin
               pop <= 1;
            end else begin
               pop <= 0;
               repeat (gap) @(posedge clock);
               pop <= 1;
            end
         end else begin
            pop <= 1;
         end
      end
   end

   // one register write through the csr channel
   task automatic write_reg(logic [vfpt_pkg::CsrIndexWidth-1:0] idx, logic [63:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx < vfpt_pkg::NumRegs) matrix_regs[idx] = value;
      @(posedge clock);
   endtask

   // one point word with a random gap ahead of it
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
      push <= 1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (full);
      board.note_point(predict_cull(x, y, z));
   endtask

   task automatic drain_unit();
      push <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
         default: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
      endcase
   endfunction

   function automatic logic [31:0] pick_point();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom();
         default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      endcase
   endfunction

   // a sensible camera: x,y kept with unit weight plus small random terms, depth = -z - offset
   task automatic load_camera(logic [31:0] sx, logic [31:0] sy,
                              logic [31:0] near_lim, logic [31:0] far_lim);
      write_reg(vfpt_pkg::RegXFirst, {32'h0001_0000, rand_word(2)});
      write_reg(vfpt_pkg::RegXSecond, {rand_word(2), rand_word(2)});
      write_reg(vfpt_pkg::RegYFirst, {rand_word(2), 32'h0001_0000});
      write_reg(vfpt_pkg::RegYSecond, {rand_word(2), rand_word(2)});
      write_reg(vfpt_pkg::RegDepthFirst, {rand_word(2), rand_word(2)});
      write_reg(vfpt_pkg::RegDepthSecond, {32'h0001_0000, rand_word(1)});
      write_reg(vfpt_pkg::RegNearFar, {near_lim, far_lim});
      write_reg(vfpt_pkg::RegScales, {sx, sy});
   endtask

   initial begin
      int phase, k;
      for (k = 0; k < vfpt_pkg::NumRegs; k++) matrix_regs[k] = '0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      popping_on = 1;

      // directed: reset registers, zero depth while inside
      send_point(0, 0, 0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      drain_unit();
      // directed: unit camera with depth = z, so centre, edge and far points all fall below near
      load_camera(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'h0010_0000);
      write_reg(vfpt_pkg::RegXSecond, 64'h0);
      write_reg(vfpt_pkg::RegYSecond, 64'h0);
      write_reg(vfpt_pkg::RegDepthFirst, 64'h0);
      write_reg(vfpt_pkg::RegDepthSecond, {32'hFFFF_0000, 32'h0});
      send_point(0, 0, 32'hFFFE_0000);           // centre, outside as depth is below near
      send_point(32'h0001_0000, 0, 32'hFFFE_0000); // half margin point, outside
      send_point(32'h0002_0000, 0, 32'hFFFE_0000); // edge point, outside
      send_point(32'h0003_0000, 0, 32'hFFFE_0000); // beyond the edge
      send_point(0, 32'hFFFD_0000, 32'hFFFE_0000);
      send_point(0, 0, 32'h0000_0000);           // below near
      send_point(0, 0, 32'hFF00_0000);           // far z, still below near
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      drain_unit();
      // directed: negative scales, extreme words, unused index
      write_reg(vfpt_pkg::RegScales, {32'h8000_0000, 32'hFFFF_0000});
      write_reg(vfpt_pkg::RegNearFar, {32'h8000_0000, 32'h7FFF_FFFF});
      write_reg(4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(4'd15, 64'h0);
      send_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_point(0, 0, 32'h7FFF_FFFF);
      drain_unit();

      // random phases over camera settings, then full-range registers
      for (phase = 0; phase < 10; phase++) begin
         if (phase == 9) begin
            for (k = 0; k < vfpt_pkg::NumRegs; k++)
               write_reg(k[vfpt_pkg::CsrIndexWidth-1:0], {$urandom(), $urandom()});
         end else begin
            load_camera(rand_word(2) + 32'h0000_8000, rand_word(2) + 32'h0000_8000,
                        (phase == 3) ? 32'h8000_0000 : rand_word(2),
                        (phase == 4) ? 32'h7FFF_FFFF : 32'h0040_0000);
         end
         for (k = 0; k < 48; k++) send_point(pick_point(), pick_point(), pick_point());
         drain_unit();
      end

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("PASS view_frustum_point_test_unit");
      end else begin
         $display("FAIL view_frustum_point_test_unit");
      end
      $finish;
   end
endmodule

/* filelist.f */
rtl/vfpt_pkg.sv
rtl/vfpt_fifo.sv
rtl/vfpt_front.sv
rtl/vfpt_back.sv
rtl/view_frustum_point_test_unit.sv
test/view_frustum_point_test_unit_test.sv
